// ----- sv/bdm_pkg.sv -----
// bdm_pkg: shared widths, constants and types of the box dilation marker
// no dependencies; compiled first
package bdm_pkg;

    // field widths fixed by the stream and register formats
    localparam int PIX_W      = 8;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // gap counter widths and their saturation points
    localparam int COL_GAP_W = 5;
    localparam int ROW_GAP_W = 6;
    localparam logic [COL_GAP_W-1:0] COL_SAT = '1;
    localparam logic [ROW_GAP_W-1:0] ROW_SAT = '1;

    // largest frame height that the height register is clamped to
    localparam int MAX_HEIGHT = 4096;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_MARK_VALUE   = 2'd2
    } t_cfg_reg;

    // position flags of one beat, worked out when the beat is taken
    typedef struct packed {
        logic in_col;    // column holds a real pixel, gap memory is touched
        logic col0;      // first column of a padded row
        logic row0;      // first row of the frame, gap memory data not used
        logic row_real;  // row holds real pixels
        logic emit;      // beat produces an output pixel
        logic last;      // beat produces the last output pixel of the frame
    } t_pix_flags;

endpackage

// ----- sv/bdm_pix_if.sv -----
// bdm_pix_if: input pixel channel, valid/ready with one pixel per beat
// depends on bdm_pkg
interface bdm_pix_if;
    logic                       valid;
    logic                       ready;
    logic [bdm_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ----- sv/bdm_res_if.sv -----
// bdm_res_if: result channel, valid/ready with output pixel and frame-end flag
// depends on bdm_pkg
interface bdm_res_if;
    logic                       valid;
    logic                       ready;
    logic [bdm_pkg::PIX_W-1:0]  out_pixel;
    logic                       frame_end;

    modport source (output valid, output out_pixel, output frame_end, input ready);
    modport sink   (input valid, input out_pixel, input frame_end, output ready);
endinterface

// ----- sv/box_dilation_marker_unit.sv -----
// box_dilation_marker_unit: top level of the rectangular binary dilation
// depends on bdm_pkg, bdm_pix_if, bdm_res_if, bdm_gap_ram, bdm_raster
//
// Usage: pixels enter on i_pix in raster order, each row followed by HALF_X
// padding beats and each frame by HALF_Y padding rows of padded length. Every
// beat at column >= HALF_X and row >= HALF_Y of the padded frame gives one
// result beat on o_res: mark_value when a nonzero real pixel lies within
// HALF_X columns and HALF_Y rows of the pixel HALF_X/HALF_Y positions back,
// else zero. frame_end marks the last result of a frame.
// Throughput: one beat per cycle unless o_res stalls. The per-column gap memory
// is read when a beat is taken and written back as stage one moves on; the same
// column comes back at least HALF_X + 1 beats later, so no forwarding is needed.
// A result goes through the stage one and output registers to o_res.
// Reset: geometry 2048 x 2048, mark 255, position at the frame start. The gap
// memory needs no clearing: the first row of a frame does not use its data.
// Stall: when o_res is not ready the output register holds; the block still
// takes beats that give no result, and one beat more into its read stage.
// Configuration writes go through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// makes them only while idle, and the block itself does not enforce it.
module box_dilation_marker_unit #(
    parameter int MAX_WIDTH = 2048,
    parameter int HALF_X    = 20,
    parameter int HALF_Y    = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bdm_pix_if.sink                         i_pix,
    bdm_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [bdm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bdm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bdm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [COL_GAP_W-1:0] V_REACH = COL_GAP_W'(2 * HALF_Y);
    localparam logic [ROW_GAP_W-1:0] H_REACH = ROW_GAP_W'(2 * HALF_X);

    t_pix_flags             pos_flags;
    logic [AW-1:0]          pos_addr;
    logic [PIX_W-1:0]       mark;
    logic                   accept;
    logic                   out_free;
    logic                   s1_adv;

    logic                   r_s1_valid;
    t_pix_flags             r_s1_flags;
    logic [PIX_W-1:0]       r_s1_pix;
    logic [AW-1:0]          r_s1_addr;
    logic [COL_GAP_W-1:0]   rd_gap;

    logic [COL_GAP_W-1:0]   old_cg, new_cg;
    logic [ROW_GAP_W-1:0]   old_rg, new_rg;
    logic                   vert;

    logic [ROW_GAP_W-1:0]   r_row_gap;
    logic                   r_out_valid;
    logic [PIX_W-1:0]       r_out_pixel;
    logic                   r_out_end;

    // position counters and geometry
    bdm_raster #(
        .MAX_WIDTH (MAX_WIDTH),
        .HALF_X    (HALF_X),
        .HALF_Y    (HALF_Y),
        .AW        (AW)
    ) u_raster (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (accept),
        .o_flags    (pos_flags),
        .o_addr     (pos_addr),
        .o_mark     (mark)
    );

    // per-column gap memory, read on accept, written when stage one moves on a real column
    bdm_gap_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (COL_GAP_W)
    ) u_gap_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv && r_s1_flags.in_col),
        .i_waddr (r_s1_addr),
        .i_wdata (new_cg),
        .i_re    (accept),
        .i_raddr (pos_addr),
        .o_rdata (rd_gap)
    );

    // handshake
    assign accept      = i_pix.valid && i_pix.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_adv      = r_s1_valid && (!r_s1_flags.emit || out_free);
    assign i_pix.ready = !r_s1_valid || s1_adv;

    // stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flags <= pos_flags;
            r_s1_pix   <= i_pix.pixel;
            r_s1_addr  <= pos_addr;
        end
    end

    // column gap update and vertical reach
    always_comb begin
        old_cg = r_s1_flags.row0 ? COL_SAT : rd_gap;
        if (r_s1_flags.row_real && (r_s1_pix != '0)) begin
            new_cg = '0;
        end else begin
            new_cg = (old_cg == COL_SAT) ? COL_SAT : old_cg + COL_GAP_W'(1);
        end
        vert = r_s1_flags.in_col && (new_cg <= V_REACH);
    end

    // row gap update for horizontal reach
    always_comb begin
        old_rg = r_s1_flags.col0 ? ROW_SAT : r_row_gap;
        if (vert) begin
            new_rg = '0;
        end else begin
            new_rg = (old_rg == ROW_SAT) ? ROW_SAT : old_rg + ROW_GAP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_gap <= ROW_SAT;
        end else if (s1_adv) begin
            r_row_gap <= new_rg;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_flags.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_flags.emit) begin
            r_out_pixel <= (new_rg <= H_REACH) ? mark : '0;
            r_out_end   <= r_s1_flags.last;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_pixel = r_out_pixel;
    assign o_res.frame_end = r_out_end;

endmodule

// ----- sv/bdm_gap_ram.sv -----
// bdm_gap_ram: per-column gap memory, one write and one registered read port
// depends on nothing; used by box_dilation_marker_unit
module bdm_gap_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered data of the address taken while i_re is high
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bdm_raster.sv -----
// bdm_raster: geometry registers and padded raster position counters
// depends on bdm_pkg; gives per-beat position flags to the top level
module bdm_raster #(
    parameter int MAX_WIDTH = 2048,
    parameter int HALF_X    = 20,
    parameter int HALF_Y    = 10,
    parameter int AW        = 11
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bdm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bdm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_step,
    output bdm_pkg::t_pix_flags                o_flags,
    output logic [AW-1:0]                      o_addr,
    output logic [bdm_pkg::PIX_W-1:0]          o_mark
);
    import bdm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + HALF_X);
    localparam int RW = $clog2(MAX_HEIGHT + HALF_Y);
    localparam int RST_W = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
    localparam int RST_H = 2048;

    logic [CW-1:0]    r_width, n_width;
    logic [CW-1:0]    r_last_col, n_last_col;
    logic [RW-1:0]    r_height, n_height;
    logic [RW-1:0]    r_last_row, n_last_row;
    logic [PIX_W-1:0] r_mark, n_mark;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [FW_W-1:0]  fw;
    logic [FH_W-1:0]  fh;
    logic [CW-1:0]    eff_w;
    logic [RW-1:0]    eff_h;

    // clamp written geometry into range
    always_comb begin
        fw = i_cfg_data[FW_W-1:0];
        fh = i_cfg_data[FH_W-1:0];
        if (fw == '0) begin
            eff_w = CW'(1);
        end else if (32'(fw) > 32'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(fw);
        end
        if (fh == '0) begin
            eff_h = RW'(1);
        end else if (32'(fh) > 32'(MAX_HEIGHT)) begin
            eff_h = RW'(MAX_HEIGHT);
        end else begin
            eff_h = RW'(fh);
        end
    end

    // register writes
    always_comb begin
        n_width    = r_width;
        n_last_col = r_last_col;
        n_height   = r_height;
        n_last_row = r_last_row;
        n_mark     = r_mark;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH: begin
                    n_width    = eff_w;
                    n_last_col = eff_w + CW'(HALF_X - 1);
                end
                REG_FRAME_HEIGHT: begin
                    n_height   = eff_h;
                    n_last_row = eff_h + RW'(HALF_Y - 1);
                end
                REG_MARK_VALUE: begin
                    n_mark = i_cfg_data[PIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // position advance, wrap at the padded row and frame ends
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (r_col >= r_last_col) begin
                n_col = '0;
                n_row = (r_row >= r_last_row) ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= CW'(RST_W);
            r_last_col <= CW'(RST_W + HALF_X - 1);
            r_height   <= RW'(RST_H);
            r_last_row <= RW'(RST_H + HALF_Y - 1);
            r_mark     <= '1;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_width    <= n_width;
            r_last_col <= n_last_col;
            r_height   <= n_height;
            r_last_row <= n_last_row;
            r_mark     <= n_mark;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    // flags of the current position
    always_comb begin
        o_flags.in_col   = r_col < r_width;
        o_flags.col0     = r_col == '0;
        o_flags.row0     = r_row == '0;
        o_flags.row_real = r_row < r_height;
        o_flags.emit     = (r_col >= CW'(HALF_X)) && (r_row >= RW'(HALF_Y))
                           && (r_col <= r_last_col) && (r_row <= r_last_row);
        o_flags.last     = (r_col == r_last_col) && (r_row == r_last_row);
    end

    assign o_addr = r_col[AW-1:0];
    assign o_mark = r_mark;

endmodule
